// ----- rtl/mfe_pkg.sv -----
// Package for the makespan and flow-time evaluator.
// Holds command and register codes, field widths, sequencer states and divider interface types.
// No dependencies.
`default_nettype none

package mfe_pkg;

   // Command codes on req_cmd
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_GENE   = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_MACHINE_COUNT = 2'd0;
   localparam logic [1:0] CSR_LOT_COUNT     = 2'd1;

   // Field widths
   localparam int TIME_W  = 24;
   localparam int END_W   = 32;
   localparam int FLOW_W  = 40;
   localparam int COUNT_W = 16;
   localparam int GENE_W  = 16;
   localparam int MCNT_W  = 6;
   localparam int LCNT_W  = 9;

   // Divider geometry
   localparam int DIV_W   = 40;
   localparam int DEN_W   = 16;
   localparam int STEP_W  = 6;
   localparam logic [STEP_W-1:0] GENE_STEPS = 6'd16;
   localparam logic [STEP_W-1:0] MEAN_STEPS = 6'd40;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GDIV,
      ST_GUPD,
      ST_GFLOW,
      ST_SCAN,
      ST_SLAST,
      ST_MDIV
   } state_type;

   // Request to the shared divider: dividend is taken MSB first, one bit per step, for steps steps
   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DEN_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DEN_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/makespan_flow_evaluator_unit.sv -----
// Load writes the time table on accept. Gene: GENE_STEPS shared divider steps, then for
// a valid decode table read, end-time update and, for a nonzero time, flow update.
// A finish reads one machine end per cycle over all MAX_MACHINES slots, then runs
// MEAN_STEPS divider steps if any gene was counted; rsp_valid pulses the cycle after.
// One item at a time; busy is high while an item is in work. Results cannot stall.
// Synchronous reset clears sums, end times and state, sets one machine; keeps the table.
`default_nettype none

module makespan_flow_evaluator_unit #(
   parameter int MAX_MACHINES = 32,
   parameter int MAX_LOTS     = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_lot,
   input  wire logic [4:0]  req_machine,
   input  wire logic [23:0] req_time_value,
   input  wire logic [15:0] req_gene,
   // result channel
   output      logic        rsp_valid,
   output      logic [31:0] rsp_makespan,
   output      logic [31:0] rsp_mean_flow_time,
   output      logic [15:0] rsp_assignment_count,
   output      logic        rsp_no_assignments,
   // register write channel
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);

   localparam int TAB_DEPTH = MAX_LOTS * MAX_MACHINES;
   localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
   localparam int MACH_AW   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

   mfe_pkg::state_type               state_ff, state_in;

   logic [mfe_pkg::MCNT_W-1:0]       mcount_ff;
   logic [mfe_pkg::LCNT_W-1:0]       lcount_ff;

   // storage
   logic [mfe_pkg::TIME_W-1:0]       tab_mem [TAB_DEPTH];
   logic [mfe_pkg::END_W-1:0]        end_mem [MAX_MACHINES];
   logic [MAX_MACHINES-1:0]          end_vld_ff;

   logic [mfe_pkg::TIME_W-1:0]       tab_rd_ff;
   logic [mfe_pkg::END_W-1:0]        end_rd_ff;
   logic                             end_hit_ff;

   logic [MACH_AW-1:0]               mach_ff;
   logic [MACH_AW-1:0]               idx_ff;
   logic                             cmp_ff;
   logic [mfe_pkg::END_W-1:0]        span_ff;
   logic [mfe_pkg::END_W-1:0]        new_end_ff;
   logic [mfe_pkg::FLOW_W-1:0]       flow_ff;
   logic [mfe_pkg::COUNT_W-1:0]      cnt_ff;

   logic                             rsp_valid_ff;
   logic [31:0]                      rsp_makespan_ff;
   logic [31:0]                      rsp_mean_ff;
   logic [15:0]                      rsp_count_ff;
   logic                             rsp_none_ff;

   mfe_pkg::div_req_type             div_req;
   mfe_pkg::div_rsp_type             div_rsp;

   logic                             accept;
   logic                             gene_ok;
   logic                             tab_rd_en;
   logic [TAB_AW-1:0]                tab_rd_addr;
   logic                             end_rd_en;
   logic [MACH_AW-1:0]               end_rd_addr;
   logic                             report_zero;
   logic                             report_mean;
   logic [mfe_pkg::END_W-1:0]        end_val;
   logic [mfe_pkg::END_W-1:0]        span_now;
   logic [mfe_pkg::END_W:0]          end_sum;
   logic [mfe_pkg::END_W-1:0]        new_end;
   logic [mfe_pkg::FLOW_W:0]         flow_sum;
   logic [15:0]                      quot_lo;

   assign accept    = start && !busy;
   assign busy      = (state_ff != mfe_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Gene decode checks on the divider result
   assign quot_lo = div_rsp.quotient[15:0];
   assign gene_ok = (quot_lo < {7'b0, lcount_ff})
                 && (32'(quot_lo) < MAX_LOTS)
                 && (32'(div_rsp.remainder) < MAX_MACHINES);
   assign tab_rd_addr = TAB_AW'(32'(quot_lo) * MAX_MACHINES + 32'(div_rsp.remainder));

   // End time of the machine just read, zero when not written since clear
   assign end_val  = end_hit_ff ? end_rd_ff : '0;
   assign span_now = (cmp_ff && (end_val > span_ff)) ? end_val : span_ff;

   // Saturating updates
   assign end_sum  = {1'b0, end_val} + (mfe_pkg::END_W+1)'(tab_rd_ff);
   assign new_end  = end_sum[mfe_pkg::END_W] ? '1 : end_sum[mfe_pkg::END_W-1:0];
   assign flow_sum = {1'b0, flow_ff} + (mfe_pkg::FLOW_W+1)'(new_end_ff);

   // Sequencer: next state and unit controls
   always_comb begin
      state_in         = state_ff;
      div_req          = '0;
      tab_rd_en        = 1'b0;
      end_rd_en        = 1'b0;
      end_rd_addr      = idx_ff;
      report_zero      = 1'b0;
      report_mean      = 1'b0;
      unique case (state_ff)
         mfe_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == mfe_pkg::CMD_GENE) begin
                  if (mcount_ff != '0) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = {req_gene, 24'b0};
                     div_req.divisor  = {10'b0, mcount_ff};
                     div_req.steps    = mfe_pkg::GENE_STEPS;
                     state_in         = mfe_pkg::ST_GDIV;
                  end
               end else if (req_cmd == mfe_pkg::CMD_FINISH) begin
                  state_in = mfe_pkg::ST_SCAN;
               end
            end
         end
         mfe_pkg::ST_GDIV: begin
            if (div_rsp.done) begin
               if (gene_ok) begin
                  tab_rd_en   = 1'b1;
                  end_rd_en   = 1'b1;
                  end_rd_addr = div_rsp.remainder[MACH_AW-1:0];
                  state_in    = mfe_pkg::ST_GUPD;
               end else begin
                  state_in = mfe_pkg::ST_IDLE;
               end
            end
         end
         mfe_pkg::ST_GUPD: begin
            state_in = (tab_rd_ff == '0) ? mfe_pkg::ST_IDLE : mfe_pkg::ST_GFLOW;
         end
         mfe_pkg::ST_GFLOW: begin
            state_in = mfe_pkg::ST_IDLE;
         end
         mfe_pkg::ST_SCAN: begin
            end_rd_en = 1'b1;
            if (idx_ff == MACH_AW'(MAX_MACHINES - 1)) begin
               state_in = mfe_pkg::ST_SLAST;
            end
         end
         mfe_pkg::ST_SLAST: begin
            if (cnt_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = flow_ff;
               div_req.divisor  = cnt_ff;
               div_req.steps    = mfe_pkg::MEAN_STEPS;
               state_in         = mfe_pkg::ST_MDIV;
            end else begin
               report_zero = 1'b1;
               state_in    = mfe_pkg::ST_IDLE;
            end
         end
         mfe_pkg::ST_MDIV: begin
            if (div_rsp.done) begin
               report_mean = 1'b1;
               state_in    = mfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfe_pkg::ST_IDLE;
         end
      endcase
   end

   mfe_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // State, configuration and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfe_pkg::ST_IDLE;
         mcount_ff    <= mfe_pkg::MCNT_W'(1);
         lcount_ff    <= '0;
         end_vld_ff   <= '0;
         flow_ff      <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         cmp_ff       <= 1'b0;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_ff       <= (state_ff == mfe_pkg::ST_SCAN);
         rsp_valid_ff <= report_zero || report_mean;

         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == mfe_pkg::CSR_MACHINE_COUNT) begin
               mcount_ff <= csr_wdata[mfe_pkg::MCNT_W-1:0];
            end else if (csr_index == mfe_pkg::CSR_LOT_COUNT) begin
               lcount_ff <= csr_wdata;
            end
         end

         // machine walk for the makespan
         if (accept && (req_cmd == mfe_pkg::CMD_FINISH)) begin
            idx_ff  <= '0;
            span_ff <= '0;
         end else begin
            if (state_ff == mfe_pkg::ST_SCAN) begin
               idx_ff <= idx_ff + 1'b1;
            end
            span_ff <= span_now;
         end

         // gene accumulation
         if ((state_ff == mfe_pkg::ST_GUPD) && (tab_rd_ff != '0)) begin
            end_vld_ff[mach_ff] <= 1'b1;
         end
         if (state_ff == mfe_pkg::ST_GFLOW) begin
            flow_ff <= flow_sum[mfe_pkg::FLOW_W] ? '1 : flow_sum[mfe_pkg::FLOW_W-1:0];
            if (cnt_ff != '1) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end

         // clear sums once reported
         if (report_zero || report_mean) begin
            end_vld_ff <= '0;
            flow_ff    <= '0;
            cnt_ff     <= '0;
         end
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (report_zero) begin
         rsp_makespan_ff <= span_now;
         rsp_mean_ff     <= '0;
         rsp_count_ff    <= cnt_ff;
         rsp_none_ff     <= 1'b1;
      end else if (report_mean) begin
         rsp_makespan_ff <= span_ff;
         rsp_mean_ff     <= (div_rsp.quotient[39:32] != '0) ? '1 : div_rsp.quotient[31:0];
         rsp_count_ff    <= cnt_ff;
         rsp_none_ff     <= 1'b0;
      end
   end

   // Processing-time table
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == mfe_pkg::CMD_LOAD)
          && (32'(req_lot) < MAX_LOTS) && (32'(req_machine) < MAX_MACHINES)) begin
         tab_mem[TAB_AW'(32'(req_lot) * MAX_MACHINES + 32'(req_machine))] <= req_time_value;
      end
      if (tab_rd_en) begin
         tab_rd_ff <= tab_mem[tab_rd_addr];
      end
   end

   // Machine end times
   always_ff @(posedge clock) begin
      if ((state_ff == mfe_pkg::ST_GUPD) && (tab_rd_ff != '0)) begin
         end_mem[mach_ff] <= new_end;
      end
      if (end_rd_en) begin
         end_rd_ff  <= end_mem[end_rd_addr];
         end_hit_ff <= end_vld_ff[end_rd_addr];
      end
   end

   // Gene pipeline payload
   always_ff @(posedge clock) begin
      if ((state_ff == mfe_pkg::ST_GDIV) && div_rsp.done) begin
         mach_ff <= div_rsp.remainder[MACH_AW-1:0];
      end
      if (state_ff == mfe_pkg::ST_GUPD) begin
         new_end_ff <= new_end;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_makespan         = rsp_makespan_ff;
   assign rsp_mean_flow_time   = rsp_mean_ff;
   assign rsp_assignment_count = rsp_count_ff;
   assign rsp_no_assignments   = rsp_none_ff;

endmodule

`default_nettype wire

// ----- rtl/mfe_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on mfe_pkg for the request and response types.
`default_nettype none

module mfe_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mfe_pkg::div_req_type req,
   output      mfe_pkg::div_rsp_type rsp
);

   logic                             busy_ff,  busy_in;
   logic                             done_ff,  done_in;
   logic [mfe_pkg::STEP_W-1:0]       cnt_ff,   cnt_in;
   logic [mfe_pkg::DIV_W-1:0]        num_ff,   num_in;
   logic [mfe_pkg::DEN_W-1:0]        rem_ff,   rem_in;
   logic [mfe_pkg::DEN_W-1:0]        den_ff,   den_in;

   logic [mfe_pkg::DEN_W:0]          trial;
   logic                             qbit;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, num_ff[mfe_pkg::DIV_W-1]};
      qbit    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[mfe_pkg::DIV_W-2:0], qbit};
         rem_in = qbit ? mfe_pkg::DEN_W'(trial - {1'b0, den_ff})
                       : trial[mfe_pkg::DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == mfe_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = num_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ----- test/makespan_flow_checker.sv -----
// Scoreboard for the makespan and flow-time evaluator: watches the command, register
// and result channels, keeps its own copy of the schedule state and checks each score.
// Depends on mfe_pkg for command codes, register indexes and field widths.
module makespan_flow_checker #(
   parameter int MAX_MACHINES = 32,
   parameter int MAX_LOTS     = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_lot,
   input  logic [4:0]  req_machine,
   input  logic [23:0] req_time_value,
   input  logic [15:0] req_gene,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_makespan,
   input  logic [31:0] rsp_mean_flow_time,
   input  logic [15:0] rsp_assignment_count,
   input  logic        rsp_no_assignments,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   output int          errors,
   output int          outstanding
);

   typedef struct {
      logic [mfe_pkg::END_W-1:0]   makespan;
      logic [31:0]                 mean_flow;
      logic [mfe_pkg::COUNT_W-1:0] count;
      logic                        empty;
   } score_type;

   score_type expected_scores[$];

   // shadow of the block's state
   logic [mfe_pkg::TIME_W-1:0]  proc_time [MAX_LOTS*MAX_MACHINES];
   logic [mfe_pkg::END_W-1:0]   mach_end [MAX_MACHINES];
   logic [mfe_pkg::FLOW_W-1:0]  flow_total;
   logic [mfe_pkg::COUNT_W-1:0] genes_taken;
   logic [mfe_pkg::MCNT_W-1:0]  cfg_machines;
   logic [mfe_pkg::LCNT_W-1:0]  cfg_lots;

   function automatic void clear_chromosome();
      foreach (mach_end[m]) mach_end[m] = '0;
      flow_total = '0;
      genes_taken = '0;
   endfunction

   // decode a gene and accumulate end time and flow, saturating
   function automatic void take_gene(input logic [mfe_pkg::GENE_W-1:0] g);
      int unsigned                lot_ix;
      int unsigned                mach_ix;
      logic [mfe_pkg::TIME_W-1:0] t;
      logic [mfe_pkg::END_W:0]    end_sum;
      logic [mfe_pkg::FLOW_W:0]   flow_sum;
      if (cfg_machines == 0) return;
      lot_ix = 32'(g) / 32'(cfg_machines);
      mach_ix = 32'(g) % 32'(cfg_machines);
      if (lot_ix >= cfg_lots || lot_ix >= MAX_LOTS) return;
      if (mach_ix >= MAX_MACHINES) return;
      t = proc_time[lot_ix*MAX_MACHINES + mach_ix];
      if (t == 0) return;
      end_sum = {1'b0, mach_end[mach_ix]} + (mfe_pkg::END_W+1)'(t);
      mach_end[mach_ix] = end_sum[mfe_pkg::END_W] ? '1 : end_sum[mfe_pkg::END_W-1:0];
      flow_sum = {1'b0, flow_total} + (mfe_pkg::FLOW_W+1)'(mach_end[mach_ix]);
      flow_total = flow_sum[mfe_pkg::FLOW_W] ? '1 : flow_sum[mfe_pkg::FLOW_W-1:0];
      if (genes_taken != '1) genes_taken++;
   endfunction

   // makespan over all machines, mean flow, then start a fresh chromosome
   function automatic score_type score_chromosome();
      logic [mfe_pkg::END_W-1:0]  span;
      logic [mfe_pkg::FLOW_W-1:0] quot;
      score_type                  s;
      span = '0;
      foreach (mach_end[m]) if (mach_end[m] > span) span = mach_end[m];
      quot = (genes_taken != 0) ? flow_total / mfe_pkg::FLOW_W'(genes_taken) : '0;
      s.makespan = span;
      s.mean_flow = (quot > 40'hFFFF_FFFF) ? '1 : quot[31:0];
      s.count = genes_taken;
      s.empty = (genes_taken == 0);
      clear_chromosome();
      return s;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         clear_chromosome();
         cfg_machines = mfe_pkg::MCNT_W'(1);
         cfg_lots = '0;
         expected_scores.delete();
         errors = 0;
         outstanding <= 0;
      end else begin
         // result transfer: compare with the oldest pending score
         if (rsp_valid) begin
            if (expected_scores.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual %0h %0h %0h %0b",
                        $time, rsp_makespan, rsp_mean_flow_time, rsp_assignment_count,
                        rsp_no_assignments);
               errors++;
            end else begin
               want = expected_scores.pop_front();
               check_field("makespan", want.makespan, rsp_makespan);
               check_field("mean_flow_time", want.mean_flow, rsp_mean_flow_time);
               check_field("assignment_count", 32'(want.count), 32'(rsp_assignment_count));
               check_field("no_assignments", 32'(want.empty), 32'(rsp_no_assignments));
            end
         end
         // register transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mfe_pkg::CSR_MACHINE_COUNT: cfg_machines = csr_wdata[mfe_pkg::MCNT_W-1:0];
               mfe_pkg::CSR_LOT_COUNT:     cfg_lots = csr_wdata;
               default: ;
            endcase
         end
         // command transfer
         if (start && !busy) begin
            case (req_cmd)
               mfe_pkg::CMD_LOAD: begin
                  if (req_lot < MAX_LOTS && req_machine < MAX_MACHINES)
                     proc_time[req_lot*MAX_MACHINES + req_machine] = req_time_value;
               end
               mfe_pkg::CMD_GENE:   take_gene(req_gene);
               mfe_pkg::CMD_FINISH: expected_scores.insert(expected_scores.size(),
                                                           score_chromosome());
               default: ;
            endcase
         end
         outstanding <= expected_scores.size();
      end
   end

endmodule

// ----- test/tb_makespan_flow_evaluator_unit.sv -----
// Testbench top for the makespan and flow-time evaluator: drives load, gene and finish
// commands and register writes through several configurations and idle patterns.
// Depends on mfe_pkg, makespan_flow_evaluator_unit and makespan_flow_checker.
module tb_makespan_flow_evaluator_unit;

   localparam int MAX_MACHINES = 32;
   localparam int MAX_LOTS     = 256;
   localparam logic [1:0] CMD_SPARE    = 2'd3;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;
   localparam int DRAIN_CYCLES = MAX_MACHINES + 64;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 85;
   localparam int SAT_GENES    = 420;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [7:0]  req_lot;
   logic [4:0]  req_machine;
   logic [23:0] req_time_value;
   logic [15:0] req_gene;
   logic        rsp_valid;
   logic [31:0] rsp_makespan;
   logic [31:0] rsp_mean_flow_time;
   logic [15:0] rsp_assignment_count;
   logic        rsp_no_assignments;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [8:0]  csr_wdata;
   int          errors;
   int          outstanding;

   int          cycles = 0;
   int          idle_pct = 0;
   int          items_sent = 0;
   logic [mfe_pkg::MCNT_W-1:0] cur_machines = mfe_pkg::MCNT_W'(1);
   logic [mfe_pkg::LCNT_W-1:0] cur_lots = '0;
   bit          loaded [MAX_LOTS*MAX_MACHINES];

   makespan_flow_evaluator_unit u_dut (.*);

   makespan_flow_checker #(
      .MAX_MACHINES(MAX_MACHINES),
      .MAX_LOTS(MAX_LOTS)
   ) u_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // mostly small times, some full width, a few zero
   function automatic logic [mfe_pkg::TIME_W-1:0] pick_time();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 60) return mfe_pkg::TIME_W'($urandom_range(1, 4096));
      if (r < 85) return mfe_pkg::TIME_W'($urandom_range(1, 1 << 20));
      return mfe_pkg::TIME_W'($urandom);
   endfunction

   // one command transfer, with a random idle gap before it
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] lot,
                            input logic [4:0] mach, input logic [23:0] tv,
                            input logic [15:0] gene);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_lot <= lot;
      req_machine <= mach;
      req_time_value <= tv;
      req_gene <= gene;
      do @(posedge clock); while (busy);
      if (cmd == mfe_pkg::CMD_LOAD) loaded[lot*MAX_MACHINES + mach] = 1'b1;
      items_sent++;
   endtask

   // a gene that would read the table gets its entry loaded first
   task automatic send_gene(input logic [15:0] g);
      int unsigned lot_ix;
      int unsigned mach_ix;
      if (cur_machines != 0) begin
         lot_ix = 32'(g) / 32'(cur_machines);
         mach_ix = 32'(g) % 32'(cur_machines);
         if (lot_ix < cur_lots && lot_ix < MAX_LOTS && mach_ix < MAX_MACHINES &&
             !loaded[lot_ix*MAX_MACHINES + mach_ix])
            send_item(mfe_pkg::CMD_LOAD, lot_ix[7:0], mach_ix[4:0], pick_time(),
                      16'($urandom));
      end
      send_item(mfe_pkg::CMD_GENE, 8'($urandom), 5'($urandom), 24'($urandom), g);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == mfe_pkg::CSR_MACHINE_COUNT) cur_machines = data[mfe_pkg::MCNT_W-1:0];
      else if (idx == mfe_pkg::CSR_LOT_COUNT) cur_lots = data;
   endtask

   // wait for every score, then let any gene still in work finish
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random chromosomes under one configuration
   task automatic run_phase(input int mc, input int lc, input int pct);
      int stop_at;
      int n;
      int r;
      int use_m;
      int use_l;
      settle();
      write_reg(mfe_pkg::CSR_MACHINE_COUNT, 9'(mc));
      write_reg(mfe_pkg::CSR_LOT_COUNT, 9'(lc));
      idle_pct = pct;
      use_m = (mc > MAX_MACHINES) ? MAX_MACHINES : mc;
      use_l = (lc > MAX_LOTS) ? MAX_LOTS : lc;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
         n = $urandom_range(0, 24);
         repeat (n) begin
            r = $urandom_range(99);
            if (r < 70 && use_m != 0 && use_l != 0)
               send_gene(16'($urandom_range(0, use_l - 1) * mc
                             + $urandom_range(0, use_m - 1)));
            else if (r < 82)
               send_gene(16'($urandom));
            else if (r < 88)
               send_gene(16'($urandom_range(0, mc * (use_l + 2))));
            else if (r < 95)
               send_item(mfe_pkg::CMD_LOAD, 8'($urandom), 5'($urandom), pick_time(),
                         16'($urandom));
            else
               send_item(CMD_SPARE, 8'($urandom), 5'($urandom), 24'($urandom),
                         16'($urandom));
         end
         send_item(mfe_pkg::CMD_FINISH, 8'($urandom), 5'($urandom), 24'($urandom),
                   16'($urandom));
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= mfe_pkg::CMD_LOAD;
      req_lot <= '0;
      req_machine <= '0;
      req_time_value <= '0;
      req_gene <= '0;
      csr_valid <= 1'b0;
      csr_index <= mfe_pkg::CSR_MACHINE_COUNT;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty score, unused command, decode edges, zero time
      send_item(mfe_pkg::CMD_FINISH, '0, '0, '0, '0);
      send_item(CMD_SPARE, 8'hFF, 5'h1F, 24'hFFFFFF, 16'hFFFF);
      settle();
      write_reg(mfe_pkg::CSR_MACHINE_COUNT, 9'd4);
      write_reg(mfe_pkg::CSR_LOT_COUNT, 9'd3);
      write_reg(CSR_SPARE_LO, 9'h1FF);
      write_reg(CSR_SPARE_HI, '0);
      send_item(mfe_pkg::CMD_LOAD, 8'd0, 5'd0, 24'hFFFFFF, '0);
      send_item(mfe_pkg::CMD_LOAD, 8'd0, 5'd1, 24'd1, '0);
      send_item(mfe_pkg::CMD_LOAD, 8'd1, 5'd2, 24'd0, '0);
      send_item(mfe_pkg::CMD_LOAD, 8'd2, 5'd3, 24'h000100, '0);
      send_item(mfe_pkg::CMD_LOAD, 8'd2, 5'd0, 24'h800000, '0);
      send_item(mfe_pkg::CMD_LOAD, 8'd255, 5'd31, 24'hFFFFFF, '0);
      send_gene(16'd0);
      send_gene(16'd1);
      send_gene(16'd6);
      send_gene(16'd11);
      send_gene(16'd8);
      send_gene(16'd12);
      send_gene(16'hFFFF);
      send_item(mfe_pkg::CMD_FINISH, '0, '0, '0, '0);
      send_item(mfe_pkg::CMD_FINISH, '0, '0, '0, '0);

      // random phases over extreme and typical settings
      run_phase(32, 256, 0);
      run_phase(32, 256, 88);
      run_phase(5, 7, 16);
      run_phase(63, 511, 0);
      run_phase(0, 64, 88);
      run_phase(1, 256, 16);
      run_phase(33, 200, 0);
      run_phase(12, 0, 16);
      run_phase(7, 300, 88);
      run_phase($urandom_range(1, 32), $urandom_range(1, 256), 16);

      // one long chromosome to saturate end time and flow sum
      settle();
      write_reg(mfe_pkg::CSR_MACHINE_COUNT, 9'd1);
      write_reg(mfe_pkg::CSR_LOT_COUNT, 9'd1);
      idle_pct = 0;
      send_item(mfe_pkg::CMD_LOAD, 8'd0, 5'd0, 24'hFFFFFF, 16'($urandom));
      repeat (SAT_GENES) send_gene(16'd0);
      send_item(mfe_pkg::CMD_FINISH, 8'($urandom), 5'($urandom), 24'($urandom),
                16'($urandom));

      settle();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
